// ----- hdl/bsvs_pkg.sv -----
// Shared constants, command codes, datapath operations and status type for the bounded value block.
`default_nettype none

package bsvs_pkg;

  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_SET       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_LINE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB_LINE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD_PAGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUB_PAGE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_RANGE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TO_POS    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_FROM_POS  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_STEP = 1'd1;

  localparam logic [STEP_W-1:0] LINE_STEP_RST = 31'd1;
  localparam logic [STEP_W-1:0] PAGE_STEP_RST = 31'd10;
  localparam logic signed [DATA_W-1:0] RANGE_MAX_RST = 32'sd99;

  // ranges above this are prescaled by 2**PRESCALE_SHIFT
  localparam logic [DATA_W-1:0] WIDE_RANGE_LIMIT = 32'd524287;
  localparam int PRESCALE_SHIFT = 13;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_CLAMP,
    OP_EARLY,
    OP_TP_MUL,
    OP_TP_DIV,
    OP_TP_FIN,
    OP_FP_DIV1,
    OP_FP_MUL1,
    OP_FP_MUL2,
    OP_FP_DIV2,
    OP_FP_FIN,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             map_early;
    logic             div_done;
  } bsvs_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bsvs_div.sv -----
// Iterative unsigned 32-bit restoring divider, one quotient bit per cycle.
`default_nettype none

module bsvs_div
  import bsvs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quot,
  output logic [DATA_W-1:0]      rem
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] quot_r, quot_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dvsr_r, dvsr_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              ge;

  assign shifted = {rem_r, quot_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvsr_r};
  assign ge      = ~trial[DATA_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quot_nxt = {quot_r[DATA_W-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- hdl/bsvs_dp.sv -----
// Datapath: value and range state, step and clamp logic, mapping arithmetic, result register.
`default_nettype none

module bsvs_dp
  import bsvs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire op_t                      op,
  output bsvs_stat_t                    stat,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [STEP_W-1:0]        cfg_wdata,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_operand_a,
  input  wire logic signed [DATA_W-1:0] in_operand_b,
  output logic signed [DATA_W-1:0]      out_current_value,
  output logic signed [DATA_W-1:0]      out_previous_value,
  output logic                          out_value_changed,
  output logic                          out_range_changed,
  output logic signed [DATA_W-1:0]      out_mapped_result
);

  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt;
  logic signed [DATA_W-1:0] b_r, b_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic signed [DATA_W-1:0] prior_r, prior_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic [STEP_W-1:0]        line_r, line_nxt;
  logic [STEP_W-1:0]        page_r, page_nxt;
  logic signed [DATA_W-1:0] cand_r, cand_nxt;
  logic                     vchg_r, vchg_nxt;
  logic                     rchg_r, rchg_nxt;
  logic [DATA_W-1:0]        mapped_r, mapped_nxt;
  logic [DATA_W-1:0]        mula_r, mula_nxt;
  logic [DATA_W-1:0]        den_r, den_nxt;
  logic [DATA_W-1:0]        prod_r, prod_nxt;
  logic [DATA_W-1:0]        t1_r, t1_nxt;
  logic signed [DATA_W-1:0] ocur_r, ocur_nxt;
  logic signed [DATA_W-1:0] oprev_r, oprev_nxt;
  logic                     ovchg_r, ovchg_nxt;
  logic                     orchg_r, orchg_nxt;
  logic [DATA_W-1:0]        omap_r, omap_nxt;

  logic [STEP_W-1:0]        step;
  logic [DATA_W:0]          sum_ext;
  logic [DATA_W:0]          dif_ext;
  logic                     up_ok;
  logic                     dn_ok;
  logic [DATA_W-1:0]        range_u;
  logic [DATA_W-1:0]        dist_u;
  logic                     wide;
  logic signed [DATA_W-1:0] clamp_src;
  logic signed [DATA_W-1:0] clamped;
  logic signed [DATA_W-1:0] new_max;
  logic                     map_early;
  logic [DATA_W-1:0]        mul_x;
  logic [DATA_W-1:0]        mul_y;
  logic [DATA_W-1:0]        mul_lo;
  logic                     div_start;
  logic [DATA_W-1:0]        div_dividend;
  logic [DATA_W-1:0]        div_divisor;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quot;
  logic [DATA_W-1:0]        div_rem;

  assign step    = (cmd_r == CMD_ADD_LINE || cmd_r == CMD_SUB_LINE) ? line_r : page_r;
  assign sum_ext = {value_r[DATA_W-1], value_r} + {2'b00, step};
  assign dif_ext = {value_r[DATA_W-1], value_r} - {2'b00, step};
  assign up_ok   = (step != '0) && (sum_ext[DATA_W] == sum_ext[DATA_W-1]);
  assign dn_ok   = (step != '0) && (dif_ext[DATA_W] == dif_ext[DATA_W-1]);

  assign range_u = max_r - min_r;
  assign dist_u  = a_r - min_r;
  assign wide    = range_u > WIDE_RANGE_LIMIT;

  assign clamp_src = (cmd_r == CMD_SET_RANGE) ? value_r : cand_r;
  assign clamped   = (clamp_src < min_r) ? min_r : ((clamp_src > max_r) ? max_r : clamp_src);
  assign new_max   = (a_r > b_r) ? a_r : b_r;

  always_comb begin
    map_early = 1'b0;
    if (cmd_r == CMD_TO_POS) begin
      map_early = (max_r <= min_r);
    end else if (cmd_r == CMD_FROM_POS) begin
      map_early = (b_r <= 0) || (a_r <= 0) || (a_r >= b_r);
    end
  end

  // one shared multiplier, low product word only
  assign mul_x  = (op == OP_TP_MUL) ? mula_r : a_r;
  assign mul_y  = (op == OP_TP_MUL) ? b_r : ((op == OP_FP_MUL1) ? div_quot : div_rem);
  assign mul_lo = mul_x * mul_y;

  assign div_start = (op == OP_TP_DIV) || (op == OP_FP_DIV1) || (op == OP_FP_DIV2);

  always_comb begin
    div_dividend = prod_r;
    div_divisor  = den_r;
    if (op == OP_FP_DIV1) begin
      div_dividend = range_u;
      div_divisor  = b_r;
    end else if (op == OP_FP_DIV2) begin
      div_dividend = {prod_r[DATA_W-2:0], 1'b0} + b_r;
      div_divisor  = {b_r[DATA_W-2:0], 1'b0};
    end
  end

  bsvs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    cmd_nxt    = cmd_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    value_nxt  = value_r;
    prior_nxt  = prior_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    line_nxt   = line_r;
    page_nxt   = page_r;
    cand_nxt   = cand_r;
    vchg_nxt   = vchg_r;
    rchg_nxt   = rchg_r;
    mapped_nxt = mapped_r;
    mula_nxt   = mula_r;
    den_nxt    = den_r;
    prod_nxt   = prod_r;
    t1_nxt     = t1_r;
    ocur_nxt   = ocur_r;
    oprev_nxt  = oprev_r;
    ovchg_nxt  = ovchg_r;
    orchg_nxt  = orchg_r;
    omap_nxt   = omap_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_STEP: line_nxt = cfg_wdata;
        REG_PAGE_STEP: page_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (op)
      OP_LOAD: begin
        cmd_nxt    = in_command;
        a_nxt      = in_operand_a;
        b_nxt      = in_operand_b;
        vchg_nxt   = 1'b0;
        rchg_nxt   = 1'b0;
        mapped_nxt = '0;
      end
      OP_PREP: begin
        case (cmd_r) inside
          CMD_SET: cand_nxt = a_r;
          CMD_ADD_LINE, CMD_ADD_PAGE: cand_nxt = up_ok ? sum_ext[DATA_W-1:0] : max_r;
          CMD_SUB_LINE, CMD_SUB_PAGE: cand_nxt = dn_ok ? dif_ext[DATA_W-1:0] : min_r;
          CMD_SET_RANGE: begin
            if (a_r != min_r || b_r != max_r) begin
              min_nxt  = a_r;
              max_nxt  = new_max;
              rchg_nxt = 1'b1;
            end
          end
          CMD_TO_POS: begin
            mula_nxt = wide ? (dist_u >> PRESCALE_SHIFT) : dist_u;
            den_nxt  = wide ? (range_u >> PRESCALE_SHIFT) : range_u;
          end
          default: ;
        endcase
      end
      OP_CLAMP: begin
        if (cmd_r == CMD_SET_RANGE) begin
          if (rchg_r && clamped != value_r) begin
            prior_nxt = value_r;
            value_nxt = clamped;
            vchg_nxt  = 1'b1;
          end
        end else begin
          prior_nxt = value_r;
          value_nxt = clamped;
          vchg_nxt  = (clamped != value_r);
        end
      end
      OP_EARLY: begin
        if (cmd_r == CMD_TO_POS) begin
          mapped_nxt = '0;
        end else begin
          mapped_nxt = ((b_r <= 0) || (a_r <= 0)) ? min_r : max_r;
        end
      end
      OP_TP_MUL:  prod_nxt   = mul_lo;
      OP_TP_DIV:  ;
      OP_TP_FIN:  mapped_nxt = div_quot;
      OP_FP_DIV1: ;
      OP_FP_MUL1: t1_nxt     = mul_lo;
      OP_FP_MUL2: prod_nxt   = mul_lo;
      OP_FP_DIV2: t1_nxt     = min_r + t1_r;
      OP_FP_FIN:  mapped_nxt = t1_r + div_quot;
      OP_OUT: begin
        ocur_nxt  = value_r;
        oprev_nxt = prior_r;
        ovchg_nxt = vchg_r;
        orchg_nxt = rchg_r;
        omap_nxt  = mapped_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      prior_r <= '0;
      min_r   <= '0;
      max_r   <= RANGE_MAX_RST;
      line_r  <= LINE_STEP_RST;
      page_r  <= PAGE_STEP_RST;
    end else begin
      value_r <= value_nxt;
      prior_r <= prior_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      line_r  <= line_nxt;
      page_r  <= page_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cand_r   <= cand_nxt;
    vchg_r   <= vchg_nxt;
    rchg_r   <= rchg_nxt;
    mapped_r <= mapped_nxt;
    mula_r   <= mula_nxt;
    den_r    <= den_nxt;
    prod_r   <= prod_nxt;
    t1_r     <= t1_nxt;
    ocur_r   <= ocur_nxt;
    oprev_r  <= oprev_nxt;
    ovchg_r  <= ovchg_nxt;
    orchg_r  <= orchg_nxt;
    omap_r   <= omap_nxt;
  end

  assign stat.cmd       = cmd_r;
  assign stat.map_early = map_early;
  assign stat.div_done  = div_done;

  assign out_current_value  = ocur_r;
  assign out_previous_value = oprev_r;
  assign out_value_changed  = ovchg_r;
  assign out_range_changed  = orchg_r;
  assign out_mapped_result  = omap_r;

endmodule

`default_nettype wire

// ----- hdl/bsvs_ctrl.sv -----
// Controller: sequences datapath operations per command and runs the channel handshakes.
`default_nettype none

module bsvs_ctrl
  import bsvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire bsvs_stat_t stat,
  output op_t             op
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_PREP     = 11'b000_0000_0010,
    S_CLAMP    = 11'b000_0000_0100,
    S_TP_MUL   = 11'b000_0000_1000,
    S_TP_DIV   = 11'b000_0001_0000,
    S_TP_WAIT  = 11'b000_0010_0000,
    S_FP_WAIT1 = 11'b000_0100_0000,
    S_FP_MUL2  = 11'b000_1000_0000,
    S_FP_DIV2  = 11'b001_0000_0000,
    S_FP_WAIT2 = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op            = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        case (stat.cmd) inside
          CMD_SET, CMD_ADD_LINE, CMD_SUB_LINE, CMD_ADD_PAGE, CMD_SUB_PAGE, CMD_SET_RANGE: begin
            op        = OP_PREP;
            state_nxt = S_CLAMP;
          end
          default: begin
            if (stat.map_early) begin
              op        = OP_EARLY;
              state_nxt = S_DONE;
            end else if (stat.cmd == CMD_TO_POS) begin
              op        = OP_PREP;
              state_nxt = S_TP_MUL;
            end else begin
              op        = OP_FP_DIV1;
              state_nxt = S_FP_WAIT1;
            end
          end
        endcase
      end
      S_CLAMP: begin
        op        = OP_CLAMP;
        state_nxt = S_DONE;
      end
      S_TP_MUL: begin
        op        = OP_TP_MUL;
        state_nxt = S_TP_DIV;
      end
      S_TP_DIV: begin
        op        = OP_TP_DIV;
        state_nxt = S_TP_WAIT;
      end
      S_TP_WAIT: begin
        if (stat.div_done) begin
          op        = OP_TP_FIN;
          state_nxt = S_DONE;
        end
      end
      S_FP_WAIT1: begin
        if (stat.div_done) begin
          op        = OP_FP_MUL1;
          state_nxt = S_FP_MUL2;
        end
      end
      S_FP_MUL2: begin
        op        = OP_FP_MUL2;
        state_nxt = S_FP_DIV2;
      end
      S_FP_DIV2: begin
        op        = OP_FP_DIV2;
        state_nxt = S_FP_WAIT2;
      end
      S_FP_WAIT2: begin
        if (stat.div_done) begin
          op        = OP_FP_FIN;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          op            = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion state");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE && out_valid_r))
    else $error("pending result overwritten");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TP_WAIT || state_r == S_FP_WAIT2) && stat.div_done) |=> (state_r == S_DONE))
    else $error("division finish not followed by completion");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input taken while a command is in flight");

endmodule

`default_nettype wire

// ----- hdl/bounded_step_value_with_scaling_top.sv -----
// Top level of the bounded step value block: controller plus datapath.
//
// Input channel (in_valid/in_ready) carries one command transaction: in_command,
// in_operand_a, in_operand_b. Result channel (out_valid/out_ready) returns one
// transaction per command: current and previous value, change flags, mapped result.
// Configuration: cfg_we with cfg_index 0 writes line_step, 1 writes page_step, taken on
// the clock edge; write only while the block is idle, the block itself does not enforce it.
// Set, step and set range commands pass through the prepare and clamp states; to
// position adds a multiply and one division, from position two multiplies and two
// divisions; a mapping command on an empty range or an edge position skips them.
// Mapping latency is set by the shared 32-bit divider, one quotient bit per cycle,
// once for to position and twice for from position. One command is in flight at
// a time; a new transaction is taken in the cycle after the previous result is
// registered.
// Reset (rst_n low, synchronous) sets value and previous value to 0, range to
// [0, 99], line_step to 1, page_step to 10, and empties the result register.
// A stalled receiver holds the result in the output register; the next command
// is still accepted and computed, then waits until the held result is taken.
`default_nettype none

module bounded_step_value_with_scaling_top
  import bsvs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [STEP_W-1:0]        cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic signed [DATA_W-1:0] in_operand_a,
  input  wire logic signed [DATA_W-1:0] in_operand_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      out_current_value,
  output logic signed [DATA_W-1:0]      out_previous_value,
  output logic                          out_value_changed,
  output logic                          out_range_changed,
  output logic signed [DATA_W-1:0]      out_mapped_result
);

  op_t        op;
  bsvs_stat_t stat;

  bsvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  bsvs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_operand_a       (in_operand_a),
    .in_operand_b       (in_operand_b),
    .out_current_value  (out_current_value),
    .out_previous_value (out_previous_value),
    .out_value_changed  (out_value_changed),
    .out_range_changed  (out_range_changed),
    .out_mapped_result  (out_mapped_result)
  );

endmodule

`default_nettype wire
